[rtl/qbe_pkg.sv]
// Shared types and constants for the quadratic Bezier evaluator.
package qbe_pkg;

  localparam int unsigned CFG_INDEX_W = 3;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_CTRL0_X = 3'd0;
  localparam cfg_index_t REG_CTRL0_Y = 3'd1;
  localparam cfg_index_t REG_CTRL1_X = 3'd2;
  localparam cfg_index_t REG_CTRL1_Y = 3'd3;
  localparam cfg_index_t REG_CTRL2_X = 3'd4;
  localparam cfg_index_t REG_CTRL2_Y = 3'd5;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } stage_en_t;

endpackage

[rtl/qbe_axis.sv]
// One coordinate axis of the four-stage Bezier datapath.
module qbe_axis #(
  parameter int COORD_WIDTH     = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  qbe_pkg::stage_en_t            en,
  input  logic [PARAM_FRAC_BITS:0]      t1,
  input  logic signed [COORD_WIDTH-1:0] p0,
  input  logic signed [COORD_WIDTH-1:0] p1,
  input  logic signed [COORD_WIDTH-1:0] p2,
  output logic signed [COORD_WIDTH-1:0] point,
  output logic signed [COORD_WIDTH+1:0] slope,
  output logic signed [COORD_WIDTH-1:0] left_mid,
  output logic signed [COORD_WIDTH-1:0] right_mid
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = PARAM_FRAC_BITS;
  localparam int MW = W + F + 4;
  localparam int EW = W + F + 3;
  localparam int BW = W + 4;
  localparam int HW = W + F + 6;
  localparam int SW = W + F;

  // stage 1: control point differences
  logic signed [W:0]   d01_nxt, d12_nxt;
  logic signed [W+1:0] dd_nxt;
  logic signed [W:0]   d01_1_r, d12_1_r;
  logic signed [W+1:0] dd_1_r;
  logic signed [W-1:0] p0_1_r, p1_1_r;

  assign d01_nxt = {p1[W-1], p1} - {p0[W-1], p0};
  assign d12_nxt = {p2[W-1], p2} - {p1[W-1], p1};
  assign dd_nxt  = {{2{p0[W-1]}}, p0} + {{2{p2[W-1]}}, p2} - {p1[W-1], p1, 1'b0};

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      d01_1_r <= d01_nxt;
      d12_1_r <= d12_nxt;
      dd_1_r  <= dd_nxt;
      p0_1_r  <= p0;
      p1_1_r  <= p1;
    end
  end

  // stage 2: products with t
  logic signed [F+1:0] ts1;
  logic signed [MW-1:0] m_nxt, m_2_r;
  logic signed [EW-1:0] e01_nxt, e12_nxt, e01_2_r, e12_2_r;
  logic [F:0]          t2_r;
  logic signed [W:0]   d01_2_r;
  logic signed [W-1:0] p0_2_r, p1_2_r;

  assign ts1     = $signed({1'b0, t1});
  assign m_nxt   = dd_1_r * ts1;
  assign e01_nxt = d01_1_r * ts1;
  assign e12_nxt = d12_1_r * ts1;

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      m_2_r   <= m_nxt;
      e01_2_r <= e01_nxt;
      e12_2_r <= e12_nxt;
      t2_r    <= t1;
      d01_2_r <= d01_1_r;
      p0_2_r  <= p0_1_r;
      p1_2_r  <= p1_1_r;
    end
  end

  // stage 3: split second-order term, midpoints and slope
  logic signed [BW-1:0] bh;
  logic [F-1:0]         bl;
  logic signed [F+1:0]  ts2;
  logic signed [HW-1:0] bht;
  logic [2*F:0]         blt;
  logic [SW-1:0]        a_nxt, a_3_r, bht_3_r;
  logic [F:0]           blt_3_r;
  logic [W-1:0]         lm_nxt, rm_nxt, lm_3_r, rm_3_r;
  logic [W+1:0]         sl_nxt, sl_3_r;

  assign bh     = m_2_r[MW-1:F];
  assign bl     = m_2_r[F-1:0];
  assign ts2    = $signed({1'b0, t2_r});
  assign bht    = bh * ts2;
  assign blt    = bl * t2_r;
  assign a_nxt  = {p0_2_r, {F{1'b0}}} + {e01_2_r[SW-2:0], 1'b0};
  assign lm_nxt = p0_2_r + e01_2_r[F +: W];
  assign rm_nxt = p1_2_r + e12_2_r[F +: W];
  assign sl_nxt = {d01_2_r, 1'b0} + m_2_r[F-1 +: W+2];

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      a_3_r   <= a_nxt;
      bht_3_r <= bht[SW-1:0];
      blt_3_r <= blt[2*F:F];
      lm_3_r  <= lm_nxt;
      rm_3_r  <= rm_nxt;
      sl_3_r  <= sl_nxt;
    end
  end

  // stage 4: final point sum
  logic [SW-1:0] sum_nxt;
  logic [W-1:0]  point_r, lm_4_r, rm_4_r;
  logic [W+1:0]  sl_4_r;

  assign sum_nxt = a_3_r + bht_3_r + {{(W-1){1'b0}}, blt_3_r};

  always_ff @(posedge clk) begin
    if (en.ld4) begin
      point_r <= sum_nxt[F +: W];
      lm_4_r  <= lm_3_r;
      rm_4_r  <= rm_3_r;
      sl_4_r  <= sl_3_r;
    end
  end

  assign point     = $signed(point_r);
  assign slope     = $signed(sl_4_r);
  assign left_mid  = $signed(lm_4_r);
  assign right_mid = $signed(rm_4_r);

endmodule

[rtl/quadratic_bezier_eval.sv]
// Quadratic Bezier evaluator top level: control registers, stage control, two axes.
// Requests pass through the stage 1 to 4 registers, one accepted per cycle
// while out_ready drains the output; stages load independently, so bubbles close up.
// Each of the four stages holds one multiplier level at most.
// Reset (rst_n low, synchronous) clears all stage valid bits and the control points to 0.
// cfg_ready is always high; a write takes effect at the next clock edge.
module quadratic_bezier_eval #(
  parameter int COORD_WIDTH     = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [PARAM_FRAC_BITS:0]        in_curve_param,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [COORD_WIDTH-1:0]   out_point_x,
  output logic signed [COORD_WIDTH-1:0]   out_point_y,
  output logic signed [COORD_WIDTH+1:0]   out_slope_x,
  output logic signed [COORD_WIDTH+1:0]   out_slope_y,
  output logic signed [COORD_WIDTH-1:0]   out_left_mid_x,
  output logic signed [COORD_WIDTH-1:0]   out_left_mid_y,
  output logic signed [COORD_WIDTH-1:0]   out_right_mid_x,
  output logic signed [COORD_WIDTH-1:0]   out_right_mid_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  qbe_pkg::cfg_index_t             cfg_index,
  input  logic [COORD_WIDTH-1:0]          cfg_data
);

  localparam int F = PARAM_FRAC_BITS;
  localparam logic [F:0] PARAM_ONE = {1'b1, {F{1'b0}}};

  // control point registers
  logic signed [COORD_WIDTH-1:0] c0x_r, c0y_r, c1x_r, c1y_r, c2x_r, c2y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0x_r <= '0;
      c0y_r <= '0;
      c1x_r <= '0;
      c1y_r <= '0;
      c2x_r <= '0;
      c2y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qbe_pkg::REG_CTRL0_X: c0x_r <= $signed(cfg_data);
        qbe_pkg::REG_CTRL0_Y: c0y_r <= $signed(cfg_data);
        qbe_pkg::REG_CTRL1_X: c1x_r <= $signed(cfg_data);
        qbe_pkg::REG_CTRL1_Y: c1y_r <= $signed(cfg_data);
        qbe_pkg::REG_CTRL2_X: c2x_r <= $signed(cfg_data);
        qbe_pkg::REG_CTRL2_Y: c2y_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // stage valid bits and load enables
  qbe_pkg::stage_en_t en;
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;

  always_comb begin
    en.ld4 = !v4_r || out_ready;
    en.ld3 = !v3_r || en.ld4;
    en.ld2 = !v2_r || en.ld3;
    en.ld1 = !v1_r || en.ld2;
    v1_nxt = en.ld1 ? in_valid : v1_r;
    v2_nxt = en.ld2 ? v1_r : v2_r;
    v3_nxt = en.ld3 ? v2_r : v3_r;
    v4_nxt = en.ld4 ? v3_r : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  assign in_ready  = en.ld1;
  assign out_valid = v4_r;

  // stage 1: saturate t to one
  logic [F:0] t1_r;

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      t1_r <= (in_curve_param > PARAM_ONE) ? PARAM_ONE : in_curve_param;
    end
  end

  qbe_axis #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_axis_x (
    .clk       (clk),
    .en        (en),
    .t1        (t1_r),
    .p0        (c0x_r),
    .p1        (c1x_r),
    .p2        (c2x_r),
    .point     (out_point_x),
    .slope     (out_slope_x),
    .left_mid  (out_left_mid_x),
    .right_mid (out_right_mid_x)
  );

  qbe_axis #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_axis_y (
    .clk       (clk),
    .en        (en),
    .t1        (t1_r),
    .p0        (c0y_r),
    .p1        (c1y_r),
    .p2        (c2y_r),
    .point     (out_point_y),
    .slope     (out_slope_y),
    .left_mid  (out_left_mid_y),
    .right_mid (out_right_mid_y)
  );

endmodule

[rtl/qbe_checker.sv]
// Port-level checks for the quadratic Bezier evaluator, bound to the top level.
module qbe_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] out_point_x
);

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled while output side can drain");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_valid && in_ready, 4) && $past(out_ready, 1) && $past(out_ready, 2) &&
     $past(out_ready, 3) && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) &&
     $past(rst_n, 4)) |-> out_valid)
    else $error("request did not arrive after four cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_point_x)))
    else $error("stalled result dropped or changed");

endmodule

bind quadratic_bezier_eval qbe_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_qbe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_point_x (out_point_x)
);

[tb/quadratic_bezier_eval_tb.sv]
// Self-checking testbench for the quadratic Bezier evaluator: directed table, then random phases.
`timescale 1ns / 100ps

module quadratic_bezier_eval_tb;

  localparam int COORD_W     = 16;
  localparam int FRAC_BITS   = 16;
  localparam int SLOPE_W     = COORD_W + 2;
  localparam int NUM_CTRL    = 6;
  localparam longint PARAM_ONE = 64'sd65536;
  localparam logic [FRAC_BITS:0] T_ONE = 17'h10000;
  localparam int SEGMENTS      = 8;
  localparam int ITEMS_PER_SEG = 250;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 400000;

  localparam qbe_pkg::cfg_index_t REG_SPARE_6 = 3'd6;
  localparam qbe_pkg::cfg_index_t REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [SLOPE_W-1:0] slope_x;
    logic signed [SLOPE_W-1:0] slope_y;
    logic signed [COORD_W-1:0] left_mid_x;
    logic signed [COORD_W-1:0] left_mid_y;
    logic signed [COORD_W-1:0] right_mid_x;
    logic signed [COORD_W-1:0] right_mid_y;
  } bezier_res_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    qbe_pkg::cfg_index_t idx;
    logic [COORD_W-1:0]  data;
    logic [FRAC_BITS:0]  t;
    logic                typed;
    bezier_res_t         res;
  } dir_row_t;

  localparam bezier_res_t RES_ZERO = '0;
  localparam bezier_res_t RES_EXTREME_T0 = '{16'sh8000, 16'sh7fff, 18'sd131070, -18'sd131070,
                                             16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
  localparam bezier_res_t RES_EXTREME_T1 = '{16'sh8000, 16'sh7fff, -18'sd131070, 18'sd131070,
                                             16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
  localparam bezier_res_t RES_FLIP_T1 = '{16'sh7fff, 16'sh7fff, 18'sd131070, 18'sd131070,
                                          16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};

  localparam int N_DIR = 37;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'd0,      1'b1, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h10000,  1'b1, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h1ffff,  1'b1, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL0_X, 16'h8000, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL0_Y, 16'h7fff, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL1_X, 16'h7fff, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL1_Y, 16'h8000, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL2_X, 16'h8000, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL2_Y, 16'h7fff, 17'd0,      1'b0, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'd0,      1'b1, RES_EXTREME_T0},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h10000,  1'b1, RES_EXTREME_T1},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h10001,  1'b1, RES_EXTREME_T1},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h08000,  1'b0, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h00001,  1'b0, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h0ffff,  1'b0, RES_ZERO},
    '{ROW_CFG,  REG_SPARE_6,          16'h1234, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  REG_SPARE_7,          16'hffff, 17'd0,      1'b0, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'd0,      1'b1, RES_EXTREME_T0},
    '{ROW_CFG,  qbe_pkg::REG_CTRL0_X, 16'h7fff, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL0_Y, 16'h7fff, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL1_X, 16'h8000, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL1_Y, 16'h8000, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL2_X, 16'h7fff, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL2_Y, 16'h7fff, 17'd0,      1'b0, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h08000,  1'b0, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'd21845,  1'b0, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h10000,  1'b1, RES_FLIP_T1},
    '{ROW_CFG,  qbe_pkg::REG_CTRL0_X, 16'h0100, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL0_Y, 16'hff00, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL1_X, 16'h0200, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL1_Y, 16'h0080, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL2_X, 16'hfe00, 17'd0,      1'b0, RES_ZERO},
    '{ROW_CFG,  qbe_pkg::REG_CTRL2_Y, 16'h0300, 17'd0,      1'b0, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h0aaaa,  1'b0, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h05555,  1'b0, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h0ffff,  1'b0, RES_ZERO},
    '{ROW_ITEM, qbe_pkg::REG_CTRL0_X, 16'h0000, 17'h1ffff,  1'b0, RES_ZERO}
  };

  logic                       clk;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic [FRAC_BITS:0]         in_curve_param = '0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic signed [COORD_W-1:0]  out_point_x;
  logic signed [COORD_W-1:0]  out_point_y;
  logic signed [SLOPE_W-1:0]  out_slope_x;
  logic signed [SLOPE_W-1:0]  out_slope_y;
  logic signed [COORD_W-1:0]  out_left_mid_x;
  logic signed [COORD_W-1:0]  out_left_mid_y;
  logic signed [COORD_W-1:0]  out_right_mid_x;
  logic signed [COORD_W-1:0]  out_right_mid_y;
  logic                       cfg_valid      = 1'b0;
  logic                       cfg_ready;
  qbe_pkg::cfg_index_t        cfg_index      = '0;
  logic [COORD_W-1:0]         cfg_data       = '0;

  logic signed [COORD_W-1:0]  ctrl_pt [NUM_CTRL] = '{default: '0};
  bezier_res_t                curve_results_q [$];
  int                         send_idle_pct  = 0;
  int                         recv_stall_pct = 0;
  int                         mismatch_count = 0;
  int                         cycle_count    = 0;

  quadratic_bezier_eval #(
    .COORD_WIDTH     (COORD_W),
    .PARAM_FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_curve_param  (in_curve_param),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_slope_x     (out_slope_x),
    .out_slope_y     (out_slope_y),
    .out_left_mid_x  (out_left_mid_x),
    .out_left_mid_y  (out_left_mid_y),
    .out_right_mid_x (out_right_mid_x),
    .out_right_mid_y (out_right_mid_y),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bezier_res_t eval_bezier(input logic [FRAC_BITS:0] t_raw);
    longint t, u, p0, p1, p2, d01, d12, pt, sl, lm, rm;
    bezier_res_t r;
    t = longint'(t_raw);
    if (t > PARAM_ONE) t = PARAM_ONE;
    u = PARAM_ONE - t;
    r = '0;
    for (int axis = 0; axis < 2; axis++) begin
      p0 = longint'(ctrl_pt[qbe_pkg::REG_CTRL0_X + axis]);
      p1 = longint'(ctrl_pt[qbe_pkg::REG_CTRL1_X + axis]);
      p2 = longint'(ctrl_pt[qbe_pkg::REG_CTRL2_X + axis]);
      d01 = p1 - p0;
      d12 = p2 - p1;
      pt = (p0 * u * u + 2 * p1 * u * t + p2 * t * t) >>> (2 * FRAC_BITS);
      sl = (2 * (d01 * u + d12 * t)) >>> FRAC_BITS;
      lm = p0 + ((d01 * t) >>> FRAC_BITS);
      rm = p1 + ((d12 * t) >>> FRAC_BITS);
      if (axis == 0) begin
        r.point_x     = pt[COORD_W-1:0];
        r.slope_x     = sl[SLOPE_W-1:0];
        r.left_mid_x  = lm[COORD_W-1:0];
        r.right_mid_x = rm[COORD_W-1:0];
      end else begin
        r.point_y     = pt[COORD_W-1:0];
        r.slope_y     = sl[SLOPE_W-1:0];
        r.left_mid_y  = lm[COORD_W-1:0];
        r.right_mid_y = rm[COORD_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic drain_results();
    while (curve_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_ctrl(input qbe_pkg::cfg_index_t idx, input logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= qbe_pkg::REG_CTRL2_Y) ctrl_pt[idx] = val;
  endtask

  task automatic send_request(input logic [FRAC_BITS:0] t, input logic typed,
                              input bezier_res_t typed_res);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_curve_param <= t;
    do @(posedge clk); while (!in_ready);
    curve_results_q.push_back(typed ? typed_res : eval_bezier(t));
  endtask

  always @(posedge clk) begin : result_monitor
    bezier_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (curve_results_q.size() == 0) begin
        $error("unexpected result: no request pending");
        mismatch_count++;
      end else begin
        want = curve_results_q.pop_front();
        check_field("point_x", longint'(want.point_x), longint'(out_point_x));
        check_field("point_y", longint'(want.point_y), longint'(out_point_y));
        check_field("slope_x", longint'(want.slope_x), longint'(out_slope_x));
        check_field("slope_y", longint'(want.slope_y), longint'(out_slope_y));
        check_field("left_mid_x", longint'(want.left_mid_x), longint'(out_left_mid_x));
        check_field("left_mid_y", longint'(want.left_mid_y), longint'(out_left_mid_y));
        check_field("right_mid_x", longint'(want.right_mid_x), longint'(out_right_mid_x));
        check_field("right_mid_y", longint'(want.right_mid_y), longint'(out_right_mid_y));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [FRAC_BITS:0] t;
    logic [COORD_W-1:0] val;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        in_valid <= 1'b0;
        drain_results();
        write_ctrl(DIRECTED[r].idx, DIRECTED[r].data);
        if (r + 1 == N_DIR || DIRECTED[r + 1].kind != ROW_CFG) cfg_valid <= 1'b0;
      end else begin
        send_request(DIRECTED[r].t, DIRECTED[r].typed, DIRECTED[r].res);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      in_valid <= 1'b0;
      drain_results();
      case (seg / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int i = qbe_pkg::REG_CTRL0_X; i <= qbe_pkg::REG_CTRL2_Y; i++) begin
        if (seg == 0) val = 16'h8000;
        else if (seg == 1) val = 16'h7fff;
        else begin
          case ($urandom_range(3))
            0: val = 16'h8000;
            1: val = 16'h7fff;
            default: val = 16'($urandom);
          endcase
        end
        write_ctrl(qbe_pkg::cfg_index_t'(i), val);
      end
      if ($urandom_range(1) != 0)
        write_ctrl(($urandom_range(1) != 0) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
      cfg_valid <= 1'b0;

      for (int n = 0; n < ITEMS_PER_SEG; n++) begin
        if (n == ITEMS_PER_SEG / 2) begin
          in_valid <= 1'b0;
          drain_results();
        end
        case ($urandom_range(9))
          0: t = ($urandom_range(1) != 0) ? T_ONE : 17'd0;
          1: t = 17'($urandom_range(131071, 65537));
          default: t = 17'($urandom_range(65536));
        endcase
        send_request(t, 1'b0, RES_ZERO);
      end
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && curve_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
